### sv/lifegen_pkg.sv
// ----------------------------------------------------------------------------
// lifegen_pkg
// Shared types, grid constants and helpers for the bounded Game of Life block.
// ----------------------------------------------------------------------------
package lifegen_pkg;

	// Grid geometry.
	localparam int GRID_ROWS  = 32;
	localparam int GRID_COLS  = 64;
	localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;

	// Field widths of the command port.
	localparam int ROW_W  = 5;
	localparam int COL_W  = 6;
	localparam int FUNC_W = 2;

	// Internal widths derived from the grid size.
	localparam int ADDR_W  = $clog2(CELL_COUNT);
	localparam int CROW_W  = $clog2(GRID_ROWS);
	localparam int CCOL_W  = $clog2(GRID_COLS);

	// Generation sweep timing: the read of a cell reaches the window through the
	// bank read register and the shift line, plus one row of look-ahead.
	localparam int WR_START  = GRID_COLS + 3;
	localparam int SCAN_LAST = CELL_COUNT + GRID_COLS + 2;
	localparam int SCAN_W    = $clog2(SCAN_LAST + 1);
	localparam int LINE_LEN  = 2 * GRID_COLS + 3;

	// B3/S23 rule constants.
	localparam int BORN_COUNT  = 3;
	localparam int CROWD_COUNT = 4;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_ADV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_en;
		logic load;
		logic scan_rst;
		logic do_write;
		logic do_read;
		logic adv_en;
		logic swap;
		logic result;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic adv_last;
	} sts_t;

	// Linear cell address in row-major order.
	function automatic addr_t cell_addr(input logic [7:0] row, input logic [7:0] col);
		logic [15:0] lin;
		lin = 16'(row) * 16'(GRID_COLS) + 16'(col);
		return lin[ADDR_W-1:0];
	endfunction

endpackage

### sv/lifegen_ctrl.sv
// ----------------------------------------------------------------------------
// lifegen_ctrl
// Controller state machine: sequences clear, write, read and generation steps.
// ----------------------------------------------------------------------------
module lifegen_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lifegen_pkg::FUNC_W-1:0] func,
	input  lifegen_pkg::sts_t         sts,
	output lifegen_pkg::cmd_t         cmd,
	output logic                      busy,
	output logic                      done
);
	import lifegen_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (func)
						FUNC_WRITE:   state_d = ST_WRITE;
						FUNC_READ:    state_d = ST_READ;
						FUNC_ADVANCE: state_d = ST_ADV;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			ST_WRITE: state_d = ST_DONE;
			ST_READ:  state_d = ST_DONE;
			ST_ADV: begin
				if (sts.adv_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clear_en = 1'b1;
			ST_IDLE: begin
				busy         = 1'b0;
				cmd.load     = start;
				cmd.scan_rst = 1'b1;
			end
			ST_WRITE: cmd.do_write = 1'b1;
			ST_READ:  cmd.do_read  = 1'b1;
			ST_ADV: begin
				cmd.adv_en = 1'b1;
				cmd.swap   = sts.adv_last;
			end
			ST_DONE: begin
				done       = 1'b1;
				cmd.result = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

### sv/lifegen_dp.sv
// ----------------------------------------------------------------------------
// lifegen_dp
// Datapath: the two cell banks, the sweep counter and the 3x3 window.
// ----------------------------------------------------------------------------
module lifegen_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lifegen_pkg::cmd_t              cmd,
	input  logic [lifegen_pkg::FUNC_W-1:0] func,
	input  logic [lifegen_pkg::ROW_W-1:0]  cell_row,
	input  logic [lifegen_pkg::COL_W-1:0]  cell_col,
	input  logic                           cell_alive,
	output lifegen_pkg::sts_t              sts,
	output logic                           read_alive,
	output logic [lifegen_pkg::FUNC_W-1:0] done_func
);
	import lifegen_pkg::*;

	logic bank_a [CELL_COUNT];
	logic bank_b [CELL_COUNT];

	logic              cur_q;
	logic [SCAN_W-1:0] scan_q;
	logic [CROW_W-1:0] ctr_row_q;
	logic [CCOL_W-1:0] ctr_col_q;
	logic [FUNC_W-1:0] func_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              alive_q;
	logic              inside_q;
	logic              rdata_a_q;
	logic              rdata_b_q;
	logic [LINE_LEN-1:0] line_q;

	addr_t       op_addr;
	addr_t       ctr_addr;
	addr_t       scan_addr;
	addr_t       rd_addr;
	addr_t       wr_addr;
	logic        wr_data;
	logic        wr_a;
	logic        wr_b;
	logic        rd_bit;
	logic        adv_wr;
	logic        top_ok;
	logic        bot_ok;
	logic        lft_ok;
	logic        rgt_ok;
	logic [3:0]  ncount;
	logic        center;
	logic        next_val;

	assign op_addr   = cell_addr(8'(row_q), 8'(col_q));
	assign ctr_addr  = cell_addr(8'(ctr_row_q), 8'(ctr_col_q));
	assign scan_addr = scan_q[ADDR_W-1:0];
	assign rd_bit    = cur_q ? rdata_b_q : rdata_a_q;
	assign adv_wr    = cmd.adv_en && (scan_q >= SCAN_W'(WR_START));

	assign sts.clr_last = (scan_q == SCAN_W'(CELL_COUNT - 1));
	assign sts.adv_last = (scan_q == SCAN_W'(SCAN_LAST));

	// Command capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q   <= func;
			row_q    <= cell_row;
			col_q    <= cell_col;
			alive_q  <= cell_alive;
			inside_q <= ({3'b000, cell_row} < 8'(GRID_ROWS)) &&
			            ({2'b00, cell_col} < 8'(GRID_COLS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= 1'b0;
			scan_q    <= '0;
			ctr_row_q <= '0;
			ctr_col_q <= '0;
		end else begin
			if (cmd.swap) begin
				cur_q <= ~cur_q;
			end
			if (cmd.scan_rst) begin
				scan_q    <= '0;
				ctr_row_q <= '0;
				ctr_col_q <= '0;
			end else if (cmd.clear_en || cmd.adv_en) begin
				scan_q <= scan_q + SCAN_W'(1);
			end
			if (adv_wr) begin
				if (ctr_col_q == CCOL_W'(GRID_COLS - 1)) begin
					ctr_col_q <= '0;
					ctr_row_q <= ctr_row_q + CROW_W'(1);
				end else begin
					ctr_col_q <= ctr_col_q + CCOL_W'(1);
				end
			end
		end
	end

	// Raster-order shift line; the center sits one row and one cell back.
	always_ff @(posedge clk) begin
		line_q <= {line_q[LINE_LEN-2:0], rd_bit};
	end

	assign top_ok = (ctr_row_q != '0);
	assign bot_ok = (ctr_row_q != CROW_W'(GRID_ROWS - 1));
	assign lft_ok = (ctr_col_q != '0);
	assign rgt_ok = (ctr_col_q != CCOL_W'(GRID_COLS - 1));
	assign center = line_q[GRID_COLS + 1];

	always_comb begin
		ncount = 4'(line_q[0] & bot_ok & rgt_ok)
		       + 4'(line_q[1] & bot_ok)
		       + 4'(line_q[2] & bot_ok & lft_ok)
		       + 4'(line_q[GRID_COLS] & rgt_ok)
		       + 4'(line_q[GRID_COLS + 2] & lft_ok)
		       + 4'(line_q[2*GRID_COLS] & top_ok & rgt_ok)
		       + 4'(line_q[2*GRID_COLS + 1] & top_ok)
		       + 4'(line_q[2*GRID_COLS + 2] & top_ok & lft_ok);
		if (center) begin
			next_val = (ncount > 4'd1) && (ncount < 4'(CROWD_COUNT));
		end else begin
			next_val = (ncount == 4'(BORN_COUNT));
		end
	end

	// Bank port steering.
	always_comb begin
		rd_addr = cmd.do_read ? op_addr : scan_addr;
		wr_addr = ctr_addr;
		wr_data = next_val;
		wr_a    = 1'b0;
		wr_b    = 1'b0;
		if (cmd.clear_en) begin
			wr_addr = scan_addr;
			wr_data = 1'b0;
			wr_a    = 1'b1;
		end else if (cmd.do_write) begin
			wr_addr = op_addr;
			wr_data = alive_q;
			wr_a    = inside_q && !cur_q;
			wr_b    = inside_q && cur_q;
		end else if (adv_wr) begin
			wr_a = cur_q;
			wr_b = !cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			bank_a[wr_addr] <= wr_data;
		end
		rdata_a_q <= bank_a[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			bank_b[wr_addr] <= wr_data;
		end
		rdata_b_q <= bank_b[rd_addr];
	end

	assign read_alive = cmd.result && (func_q == FUNC_READ) && inside_q && rd_bit;
	assign done_func  = func_q;

endmodule

### sv/life_automaton_generation_top.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_top
// Bounded Game of Life grid (B3/S23) with cell write, cell read and advance.
// ----------------------------------------------------------------------------
// Sequence: a write or read passes through its own state before done strobes,
// an unused code goes straight to done, and an advance first sweeps the grid
// at one bank read per cycle.
// Throughput: one command at a time; busy is low again the cycle after done.
// Reset: clears control state, then a pass over every cell writes the first bank dead.
// The receiver cannot stall: each result is shown for exactly one cycle.
module life_automaton_generation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	output logic                           done,
	input  logic [lifegen_pkg::FUNC_W-1:0] func,
	input  logic [lifegen_pkg::ROW_W-1:0]  cell_row,
	input  logic [lifegen_pkg::COL_W-1:0]  cell_col,
	input  logic                           cell_alive,
	output logic                           read_alive,
	output logic [lifegen_pkg::FUNC_W-1:0] done_func
);
	import lifegen_pkg::*;

	// The controller decides what happens each cycle; the datapath holds the
	// two banks, the sweep counter and the neighborhood window.
	cmd_t cmd;
	sts_t sts;

	// Sequencing of each transfer: capture the fields, run the operation,
	// then present the result for one cycle.
	lifegen_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// During an advance the datapath streams the current bank in raster order
	// through a shift line two rows deep, and each cell's successor is written
	// into the other bank once its lower-right neighbor has arrived. The banks
	// swap roles on the last write.
	lifegen_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_alive (cell_alive),
		.sts        (sts),
		.read_alive (read_alive),
		.done_func  (done_func)
	);

endmodule

### sv/lifegen_checker.sv
// ----------------------------------------------------------------------------
// lifegen_checker
// Port-level checks on the command and result timing of the grid block.
// ----------------------------------------------------------------------------
module lifegen_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [lifegen_pkg::FUNC_W-1:0] func,
	input logic                           read_alive,
	input logic [lifegen_pkg::FUNC_W-1:0] done_func
);
	import lifegen_pkg::*;

	// An accepted command makes the block busy.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted command");

	// After a result the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after a result");

	// Only a read result may carry a live cell.
	a_alive_read: assert property (@(posedge clk) disable iff (!arst_n)
		(!done || done_func != FUNC_READ) |-> !read_alive)
		else $error("read_alive set outside a read result");

	// Writes and reads finish in fixed time and echo their code.
	a_cell_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (func == FUNC_WRITE || func == FUNC_READ))
		|=> ##1 (done && done_func == $past(func, 2)))
		else $error("cell access result late or wrong code");

endmodule

bind life_automaton_generation_top lifegen_checker u_lifegen_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.func       (func),
	.read_alive (read_alive),
	.done_func  (done_func)
);
